// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the oil temperature estimator rtl
// no dependencies; bodies compile away when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ===== hw/rtl/otle_pkg.sv =====
// types, constants and helpers for the oil temperature lag estimator
// no dependencies
package otle_pkg;

  // fraction bits of the lagged drop
  localparam int DropFracBits = 8;
  localparam int ShUp = (DropFracBits >= 8) ? DropFracBits - 8 : 0;
  localparam int ShDn = (DropFracBits >= 8) ? 0 : 8 - DropFracBits;

  localparam int MaxDtMs          = 1000;
  localparam int CeilingTemp      = 1767;
  localparam int DefaultFloorTemp = -400;
  localparam int PrevReset        = 10000;
  localparam int FallbackReset    = 900;

  // shared multiplier and serial divider widths
  localparam int MulAW    = 33;
  localparam int MulBW    = 17;
  localparam int ProdW    = MulAW + MulBW;
  localparam int AccW     = 34;
  localparam int WideW    = 48;
  localparam int DivNumW  = 42;
  localparam int DivDenW  = 16;

  localparam logic signed [WideW-1:0] Sat32Max = 48'sh0000_7FFF_FFFF;
  localparam logic signed [WideW-1:0] Sat32Min = 48'shFFFF_8000_0000;

  typedef enum logic [2:0] {
    REG_OFFSET_K0  = 3'd0,
    REG_GAIN_HEAD  = 3'd1,
    REG_GAIN_AIR   = 3'd2,
    REG_GAIN_PRESS = 3'd3,
    REG_TAU_HEAT   = 3'd4,
    REG_TAU_COOL   = 3'd5,
    REG_FALLBACK   = 3'd6
  } reg_idx_e;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b000_0001,
    S_PROD   = 7'b000_0010,
    S_TGT    = 7'b000_0100,
    S_DMUL   = 7'b000_1000,
    S_DSTART = 7'b001_0000,
    S_DIV    = 7'b010_0000,
    S_EST    = 7'b100_0000
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [31:0] r;
    if (v > Sat32Max) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < Sat32Min) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/otle_mul.sv =====
// shared signed multiplier with registered product
// depends on nothing; widths come from the instantiating module
module otle_mul #(
  parameter int AW = 33,
  parameter int BW = 17
) (
  input  logic                     clk_i,
  input  logic signed [AW-1:0]     a_i,
  input  logic signed [BW-1:0]     b_i,
  output logic signed [AW+BW-1:0]  p_o
);

  logic signed [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/otle_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on nothing; unsigned operands, divisor must be nonzero
module otle_div #(
  parameter int NumW = 42,
  parameter int DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [DenW-1:0] divisor_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;
  logic            qbit;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    trial  = {rem_q, num_q[NumW-1]};
    qbit   = (trial >= {1'b0, den_q});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      rem_d  = '0;
      num_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low bits are enough
      rem_d = qbit ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      num_d = {num_q[NumW-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== hw/rtl/oil_temp_lag_estimator.sv =====
// channel   dir  handshake                    payload
// update    in   s_axis_tvalid/s_axis_tready  tdata: readings, tuser: valid flags
// estimate  out  m_axis_tvalid/m_axis_tready  tdata: estimate, tuser: used_fallback
// config    in   psel/penable/pwrite (apb)    7 registers at byte address 4*i
//
// fallback items go straight from idle to the estimate state; others run the gain
// products and the target step and, when the selected time constant is not 0, the
// 42-step serial divider for elapsed over tau; the four products share one multiplier.
// one item at a time: s_axis_tready is high only while the sequencer is idle.
// rst_ni clears the lagged drop, sets the previous estimate to 10000 and
// loads register defaults; a stalled estimate holds in its output register.
//
// oil temperature lag estimator top level
// depends on otle_pkg, otle_mul, otle_div and assert_macros.svh
`include "assert_macros.svh"

module oil_temp_lag_estimator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // elapsed_ms[15:0], head_temp[28:16], oil_pressure[42:29],
  // intake_air_temp[54:43], ambient_temp[66:55], engine_speed[81:67]
  input  logic [87:0] s_axis_tdata,
  // head_temp_ok[0], oil_pressure_ok[1], intake_air_ok[2], ambient_ok[3]
  input  logic [3:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // oil_temp_estimate[12:0]
  output logic [15:0] m_axis_tdata,
  // used_fallback[0]
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import otle_pkg::*;

  // configuration registers
  logic signed [15:0] k0_q, gh_q, ga_q, gp_q;
  logic [15:0]        tau_heat_q, tau_cool_q;
  logic [12:0]        fallback_q;
  reg_idx_e           reg_idx;
  logic               cfg_wr;

  // control and state
  state_e             state_q, state_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] drop_q, drop_d;
  logic signed [15:0] prev_q, prev_d;
  logic               bad_accept, prev_in_range;

  // item payload
  logic [9:0]          dt_q;
  logic signed [12:0]  head_q, air_q, flr_q;
  logic [13:0]         press_q;
  logic                circ_q, fb_q, neg_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [32:0]  diff_q;
  logic [15:0]         tau_q;
  logic signed [31:0]  newdrop_q, newdrop_d;
  logic [12:0]         out_est_q;
  logic                out_fb_q;

  // input unpacking
  logic [15:0]        in_elapsed;
  logic signed [12:0] in_head;
  logic [13:0]        in_press;
  logic signed [11:0] in_intake, in_amb;
  logic [14:0]        in_rpm;
  logic               in_accept;

  // shared units
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic                    div_start, div_done;
  logic [DivNumW-1:0]      div_num, div_quot;

  // combinational datapath
  logic signed [WideW-1:0] scaled, off_w, tgt_w, est_w, flr_w, ceil_w, dsum_w, reld_w;
  logic signed [31:0]      target_raw, target_eff, drop_fin;
  logic signed [32:0]      diff_d;
  logic signed [43:0]      qsig;
  logic signed [15:0]      est16;
  logic                    load_out;

  assign in_elapsed = s_axis_tdata[15:0];
  assign in_head    = s_axis_tdata[28:16];
  assign in_press   = s_axis_tdata[42:29];
  assign in_intake  = s_axis_tdata[54:43];
  assign in_amb     = s_axis_tdata[66:55];
  assign in_rpm     = s_axis_tdata[81:67];
  assign in_accept  = s_axis_tvalid && s_axis_tready;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_OFFSET_K0:  prdata = {16'b0, k0_q};
      REG_GAIN_HEAD:  prdata = {16'b0, gh_q};
      REG_GAIN_AIR:   prdata = {16'b0, ga_q};
      REG_GAIN_PRESS: prdata = {16'b0, gp_q};
      REG_TAU_HEAT:   prdata = {16'b0, tau_heat_q};
      REG_TAU_COOL:   prdata = {16'b0, tau_cool_q};
      REG_FALLBACK:   prdata = {19'b0, fallback_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k0_q       <= '0;
      gh_q       <= '0;
      ga_q       <= '0;
      gp_q       <= '0;
      tau_heat_q <= '0;
      tau_cool_q <= '0;
      fallback_q <= 13'(FallbackReset);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_OFFSET_K0:  k0_q       <= pwdata[15:0];
        REG_GAIN_HEAD:  gh_q       <= pwdata[15:0];
        REG_GAIN_AIR:   ga_q       <= pwdata[15:0];
        REG_GAIN_PRESS: gp_q       <= pwdata[15:0];
        REG_TAU_HEAT:   tau_heat_q <= pwdata[15:0];
        REG_TAU_COOL:   tau_cool_q <= pwdata[15:0];
        REG_FALLBACK:   fallback_q <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------- shared units ----------------
  otle_mul #(
    .AW (MulAW),
    .BW (MulBW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  otle_div #(
    .NumW (DivNumW),
    .DenW (DivDenW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (tau_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // operand select: three gain products, then difference times elapsed
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_DMUL) begin
      mul_a = diff_q;
      mul_b = $signed({7'b0, dt_q});
    end else begin
      case (cnt_q)
        2'd0: begin
          mul_a = $signed({{20{head_q[12]}}, head_q});
          mul_b = $signed({gh_q[15], gh_q});
        end
        2'd1: begin
          mul_a = $signed({{20{air_q[12]}}, air_q});
          mul_b = $signed({ga_q[15], ga_q});
        end
        2'd2: begin
          mul_a = $signed({19'b0, press_q});
          mul_b = $signed({gp_q[15], gp_q});
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign div_start = (state_q == S_DSTART);
  assign div_num   = mul_p[ProdW-1] ? DivNumW'(-mul_p) : mul_p[DivNumW-1:0];

  // ---------------- target drop ----------------
  always_comb begin
    scaled = ($signed({{(WideW-AccW){acc_q[AccW-1]}}, acc_q}) <<< ShUp) >>> ShDn;
    off_w  = $signed({{(WideW-16){k0_q[15]}}, k0_q}) <<< DropFracBits;
    tgt_w  = off_w + scaled;
    target_raw = sat32(tgt_w);
    // without circulation the drop may only grow
    target_eff = (!circ_q && (target_raw < drop_q)) ? drop_q : target_raw;
    diff_d = $signed({target_eff[31], target_eff}) - $signed({drop_q[31], drop_q});
  end

  // quotient back to signed, truncated toward zero
  assign qsig   = neg_q ? -$signed({2'b0, div_quot}) : $signed({2'b0, div_quot});
  assign dsum_w = $signed({{16{drop_q[31]}}, drop_q}) + $signed({{4{qsig[43]}}, qsig});

  // ---------------- estimate ----------------
  assign ceil_w = WideW'(CeilingTemp);
  assign flr_w  = $signed({{(WideW-13){flr_q[12]}}, flr_q});

  always_comb begin
    est_w = (($signed({{(WideW-13){head_q[12]}}, head_q}) <<< DropFracBits)
            - $signed({{16{newdrop_q[31]}}, newdrop_q})) >>> DropFracBits;
    if (est_w > ceil_w) begin
      est_w = ceil_w;
    end
    if (est_w < flr_w) begin
      est_w = flr_w;
    end
    est16 = est_w[15:0];
    if (!circ_q && (est16 > prev_q)) begin
      est16 = prev_q;
    end
    reld_w = ($signed({{(WideW-13){head_q[12]}}, head_q})
             - $signed({{(WideW-16){est16[15]}}, est16})) <<< DropFracBits;
    drop_fin = circ_q ? newdrop_q : sat32(reld_w);
  end

  // ---------------- sequencer ----------------
  assign s_axis_tready = (state_q == S_IDLE);
  assign load_out      = (state_q == S_EST) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    newdrop_d   = newdrop_q;
    drop_d      = drop_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cnt_d   = '0;
          acc_d   = '0;
          state_d = (s_axis_tuser[0] && s_axis_tuser[1]) ? S_PROD : S_EST;
        end
      end
      S_PROD: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != 2'd0) begin
          acc_d = acc_q + $signed(mul_p[AccW-1:0]);
        end
        if (cnt_q == 2'd3) begin
          state_d = S_TGT;
        end
      end
      S_TGT: begin
        if (((target_eff < drop_q) ? tau_heat_q : tau_cool_q) == 16'd0) begin
          newdrop_d = target_eff;
          state_d   = S_EST;
        end else begin
          state_d = S_DMUL;
        end
      end
      S_DMUL: begin
        state_d = S_DSTART;
      end
      S_DSTART: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          newdrop_d = sat32(dsum_w);
          state_d   = S_EST;
        end
      end
      S_EST: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          if (!fb_q) begin
            drop_d = drop_fin;
            prev_d = est16;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      drop_q      <= '0;
      prev_q      <= 16'(PrevReset);
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      drop_q      <= drop_d;
      prev_q      <= prev_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    newdrop_q <= newdrop_d;
    if (in_accept) begin
      dt_q    <= (in_elapsed > 16'(MaxDtMs)) ? 10'(MaxDtMs) : in_elapsed[9:0];
      head_q  <= in_head;
      press_q <= in_press;
      fb_q    <= !(s_axis_tuser[0] && s_axis_tuser[1]);
      circ_q  <= (in_rpm != '0) && (in_press != '0);
      // air for the drop: intake, else ambient, else head
      air_q   <= s_axis_tuser[2] ? 13'(in_intake) :
                 (s_axis_tuser[3] ? 13'(in_amb) : in_head);
      flr_q   <= s_axis_tuser[2] ? 13'(in_intake) :
                 (s_axis_tuser[3] ? 13'(in_amb) : 13'(DefaultFloorTemp));
    end
    if (state_q == S_TGT) begin
      diff_q <= diff_d;
      tau_q  <= (target_eff < drop_q) ? tau_heat_q : tau_cool_q;
    end
    if (state_q == S_DSTART) begin
      neg_q <= mul_p[ProdW-1];
    end
    if (load_out) begin
      out_est_q <= fb_q ? fallback_q : est16[12:0];
      out_fb_q  <= fb_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b0, out_est_q};
  assign m_axis_tuser  = out_fb_q;

  // ---------------- assertions ----------------
  assign bad_accept    = in_accept && !(s_axis_tuser[0] && s_axis_tuser[1]);
  assign prev_in_range = (prev_q == 16'(PrevReset)) ||
                         ((prev_q <= 16'sd2047) && (prev_q >= -16'sd2048));

  `ASSERT_AT(a_div_done_in_div, clk_i, rst_ni, div_done |-> (state_q == S_DIV))
  `ASSERT_AT(a_bad_sensor_fallback, clk_i, rst_ni, bad_accept |=> ((state_q == S_EST) && fb_q))
  `ASSERT_AT(a_prev_range, clk_i, rst_ni, prev_in_range)

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for oil_temp_lag_estimator: drives update transfers and
// apb register writes, predicts every estimate in sv and compares it per field
// depends on otle_pkg and the oil_temp_lag_estimator rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import otle_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 60;

  typedef struct {
    logic [15:0]        elapsed;
    logic signed [12:0] head;
    logic               head_ok;
    logic [13:0]        press;
    logic               press_ok;
    logic signed [11:0] intake;
    logic               intake_ok;
    logic signed [11:0] amb;
    logic               amb_ok;
    logic [14:0]        rpm;
  } update_t;

  typedef struct {
    logic signed [12:0] est;
    logic               fallback;
  } estimate_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  // elapsed_ms, head_temp, oil_pressure, intake_air_temp, ambient_temp, engine_speed
  logic [87:0] s_axis_tdata = '0;
  // head_temp_ok, oil_pressure_ok, intake_air_ok, ambient_ok
  logic [3:0]  s_axis_tuser = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // oil_temp_estimate
  logic [15:0] m_axis_tdata;
  // used_fallback
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the registers and the lag state
  logic signed [15:0] cfg_offset_k0 = '0;
  logic signed [15:0] cfg_gain_head = '0;
  logic signed [15:0] cfg_gain_air = '0;
  logic signed [15:0] cfg_gain_press = '0;
  logic [15:0]        cfg_tau_heat = '0;
  logic [15:0]        cfg_tau_cool = '0;
  logic signed [12:0] cfg_fallback = 13'(FallbackReset);
  int                 lagged_drop = 0;
  int                 prev_estimate = PrevReset;

  estimate_t estimate_q[$];
  bit        idle_on = 1'b1;
  int        rx_hold_cycles = 0;
  int        err_count = 0;
  int        cycle_count = 0;
  int        sent_count = 0;
  int        fallback_count = 0;
  int        checked_count = 0;
  int        settings_count = 0;

  oil_temp_lag_estimator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d estimates pending", cycle_count,
               estimate_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic longint clamp_i32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // one update step: target drop, lag toward it, estimate with limits
  function automatic estimate_t predict_oil_temp(update_t u);
    estimate_t r;
    longint dt, head, press, air, flr, sum, target, d, nd, tau, est, one;
    bit circ;
    one = longint'(1) << DropFracBits;
    dt = longint'(u.elapsed);
    if (dt > MaxDtMs) dt = MaxDtMs;
    if (!u.head_ok || !u.press_ok) begin
      r.est = cfg_fallback;
      r.fallback = 1'b1;
      return r;
    end
    head = longint'(u.head);
    press = longint'(u.press);
    air = u.intake_ok ? longint'(u.intake) : (u.amb_ok ? longint'(u.amb) : head);
    flr = u.intake_ok ? longint'(u.intake)
                      : (u.amb_ok ? longint'(u.amb) : longint'(DefaultFloorTemp));
    circ = (u.rpm != 0) && (press != 0);
    sum = longint'(cfg_gain_head) * head + longint'(cfg_gain_air) * air
        + longint'(cfg_gain_press) * press;
    sum = (sum <<< ShUp) >>> ShDn;
    target = clamp_i32(longint'(cfg_offset_k0) * one + sum);
    d = longint'(lagged_drop);
    // stalled oil: the drop may only grow
    if (!circ && target < d) target = d;
    tau = (target < d) ? longint'(cfg_tau_heat) : longint'(cfg_tau_cool);
    if (tau > 0) nd = clamp_i32(d + ((target - d) * dt) / tau);
    else nd = target;
    est = (head * one - nd) >>> DropFracBits;
    if (est > CeilingTemp) est = CeilingTemp;
    if (est < flr) est = flr;
    if (!circ) begin
      if (est > longint'(prev_estimate)) est = longint'(prev_estimate);
      nd = clamp_i32((head - est) * one);
    end
    lagged_drop = int'(nd);
    prev_estimate = int'(est);
    r.est = est[12:0];
    r.fallback = 1'b0;
    return r;
  endfunction

  function automatic update_t mk_update(int el, int hd, bit hok, int pr, bit pok,
                                        int ia, bit iok, int am, bit aok, int rpm);
    update_t u;
    u.elapsed = el[15:0];
    u.head = hd[12:0];
    u.head_ok = hok;
    u.press = pr[13:0];
    u.press_ok = pok;
    u.intake = ia[11:0];
    u.intake_ok = iok;
    u.amb = am[11:0];
    u.amb_ok = aok;
    u.rpm = rpm[14:0];
    return u;
  endfunction

  // mostly plausible running-engine readings, the rest raw noise
  function automatic update_t rand_update(bit well_formed);
    update_t u;
    int el, pr, rpm;
    if (!well_formed) begin
      return mk_update($urandom, $urandom, 1'($urandom_range(1)), $urandom,
                       1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                       $urandom, 1'($urandom_range(1)), $urandom);
    end
    el = ($urandom_range(15) == 0) ? int'($urandom_range(65535))
                                   : int'($urandom_range(1100));
    pr = ($urandom_range(15) == 0) ? 0 : int'($urandom_range(10000));
    rpm = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(20000));
    u = mk_update(el, int'($urandom_range(4400)) - 400, 1'b1, pr, 1'b1,
                  int'($urandom_range(1900)) - 400, $urandom_range(9) != 0,
                  int'($urandom_range(1900)) - 400, $urandom_range(3) != 0, rpm);
    return u;
  endfunction

  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else begin
      m_axis_tready <= !idle_on || ($urandom_range(99) >= 24);
    end
  end

  always @(posedge clk_i) begin
    estimate_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (estimate_q.size() == 0) begin
        err_count++;
        $display("%t: estimate transfer with none expected: est %0d fallback %0b", $time,
                 $signed(m_axis_tdata[12:0]), m_axis_tuser[0]);
      end else begin
        want = estimate_q.pop_front();
        checked_count++;
        if (m_axis_tdata[12:0] !== want.est) begin
          err_count++;
          $display("%t: oil_temp_estimate expected %0d actual %0d", $time, want.est,
                   $signed(m_axis_tdata[12:0]));
        end
        if (m_axis_tuser[0] !== want.fallback) begin
          err_count++;
          $display("%t: used_fallback expected %0b actual %0b", $time, want.fallback,
                   m_axis_tuser[0]);
        end
      end
    end
  end

  task automatic send_update(update_t u);
    estimate_t r;
    int gap;
    gap = (idle_on && $urandom_range(99) < 24) ? int'($urandom_range(1, 6)) : 0;
    @(negedge clk_i);
    for (int i = 0; i < gap; i++) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {6'b0, u.rpm, u.amb, u.intake, u.press, u.head, u.elapsed};
    s_axis_tuser <= {u.amb_ok, u.intake_ok, u.press_ok, u.head_ok};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_oil_temp(u);
    estimate_q.push_back(r);
    sent_count++;
    if (r.fallback) fallback_count++;
  endtask

  // sender stops offering until every estimate has come back
  task automatic wait_for_estimates();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (estimate_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper bits of each write carry junk that the register must drop
  task automatic load_settings(int k0, int gh, int ga, int gp, int th, int tc, int fb);
    write_reg(REG_OFFSET_K0, {16'($urandom), k0[15:0]});
    write_reg(REG_GAIN_HEAD, {16'($urandom), gh[15:0]});
    write_reg(REG_GAIN_AIR, {16'($urandom), ga[15:0]});
    write_reg(REG_GAIN_PRESS, {16'($urandom), gp[15:0]});
    write_reg(REG_TAU_HEAT, {16'($urandom), th[15:0]});
    write_reg(REG_TAU_COOL, {16'($urandom), tc[15:0]});
    write_reg(REG_FALLBACK, {19'($urandom), fb[12:0]});
    cfg_offset_k0 = k0[15:0];
    cfg_gain_head = gh[15:0];
    cfg_gain_air = ga[15:0];
    cfg_gain_press = gp[15:0];
    cfg_tau_heat = th[15:0];
    cfg_tau_cool = tc[15:0];
    cfg_fallback = fb[12:0];
    settings_count++;
  endtask

  // register defaults: missing sensors, then a head temp clamped to the ceiling with zero drop
  task automatic test_sensor_fallback();
    send_update(mk_update(100, 900, 0, 3000, 1, 250, 1, 200, 1, 2000));
    send_update(mk_update(100, 900, 1, 3000, 0, 250, 1, 200, 1, 2000));
    send_update(mk_update(65535, -4096, 0, 16383, 0, -2048, 0, -2048, 0, 32767));
    send_update(mk_update(50, 4095, 1, 2000, 1, 250, 1, 200, 1, 3000));
    wait_for_estimates();
  endtask

  task automatic test_field_extremes();
    load_settings(100, 40, -20, 3, 0, 0, -400);
    // floor above ceiling
    send_update(mk_update(0, -4096, 1, 16383, 1, 2047, 1, 0, 0, 32767));
    // ambient as air source
    send_update(mk_update(1000, 4000, 1, 3000, 1, 0, 0, -2048, 1, 2500));
    // no air reading at all: head as air, default floor
    send_update(mk_update(1001, 1200, 1, 2500, 1, 0, 0, 0, 0, 2500));
    // no circulation by speed, then by pressure
    send_update(mk_update(500, 1500, 1, 2500, 1, 300, 1, 200, 1, 0));
    send_update(mk_update(500, 1600, 1, 0, 1, 300, 1, 200, 1, 20000));
    send_update(mk_update(65535, 2000, 1, 10000, 1, -400, 1, 1500, 1, 1));
    wait_for_estimates();
  endtask

  task automatic test_lag_direction();
    load_settings(200, 30, 10, 1, 500, 4000, 3000);
    send_update(mk_update(100, 1500, 1, 3000, 1, 250, 1, 200, 1, 3000));
    send_update(mk_update(1000, 1500, 1, 3000, 1, 250, 1, 200, 1, 3000));
    send_update(mk_update(1000, 200, 1, 3000, 1, 250, 1, 200, 1, 3000));
    send_update(mk_update(1, 3000, 1, 3000, 1, 250, 1, 200, 1, 3000));
    wait_for_estimates();
    // elapsed far beyond tau: the step overshoots
    load_settings(-500, 60, -30, 4, 3, 7, 1234);
    send_update(mk_update(1000, 1500, 1, 4000, 1, 300, 1, 200, 1, 3000));
    send_update(mk_update(1000, 400, 1, 4000, 1, 300, 1, 200, 1, 3000));
    send_update(mk_update(900, 2500, 1, 4000, 1, 300, 1, 200, 1, 3000));
    wait_for_estimates();
  endtask

  // estimate side holds off while updates keep coming
  task automatic test_backpressure();
    @(posedge clk_i);
    rx_hold_cycles = 400;
    for (int i = 0; i < 15; i++) send_update(rand_update($urandom_range(99) < 85));
    wait_for_estimates();
  endtask

  task automatic test_random_settings();
    int k0, gh, ga, gp, th, tc, fb;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_settings(32767, 32767, 32767, 32767, 65535, 65535, 3000);
        1: load_settings(-32768, -32768, -32768, -32768, 0, 0, -400);
        2: load_settings($urandom, $urandom, $urandom, $urandom, 1, 1, -4096);
        default: begin
          if (ph % 2 == 1) begin
            k0 = int'($urandom_range(4000)) - 2000;
            gh = int'($urandom_range(128)) - 32;
            ga = int'($urandom_range(128)) - 64;
            gp = int'($urandom_range(16)) - 8;
            fb = int'($urandom_range(3400)) - 400;
          end else begin
            k0 = $urandom;
            gh = $urandom;
            ga = $urandom;
            gp = $urandom;
            fb = $urandom;
          end
          th = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(1, 20000));
          tc = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(1, 20000));
          if ($urandom_range(3) == 0) th = $urandom_range(1, 50);
          load_settings(k0, gh, ga, gp, th, tc, fb);
        end
      endcase
      // one phase runs at full rate on both sides
      idle_on = (ph != 6);
      for (int i = 0; i < 128; i++) send_update(rand_update($urandom_range(99) < 85));
      wait_for_estimates();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_sensor_fallback();
    test_field_extremes();
    test_lag_direction();
    test_backpressure();
    test_random_settings();
    wait_for_estimates();
    repeat (DrainCycles) @(posedge clk_i);
    $display("run covered %0d updates (%0d with missing sensors) over %0d register settings",
             sent_count, fallback_count, settings_count);
    $display("%0d estimates checked, %0d mismatches", checked_count, err_count);
    if (err_count == 0 && estimate_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== oil_temp_lag_estimator.f =====
+incdir+hw/rtl
hw/rtl/otle_pkg.sv
hw/rtl/otle_mul.sv
hw/rtl/otle_div.sv
hw/rtl/oil_temp_lag_estimator.sv
tb/tb_top.sv
